// ----- design/kabf_pkg.sv -----
// Shared types, register indexes, sequencer codes and saturating/rounding
// helpers for the angle and gyro-bias Kalman filter. No dependencies.
package kabf_pkg;

    localparam int DATA_W = 32;
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;
    localparam int CFG_W  = 28;
    localparam int CIDX_W = 2;
    localparam int MEAS_W = 25;
    localparam int DT_W   = 20;

    typedef logic signed [DATA_W-1:0] t_q;
    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PROD_W:0]   t_delta;
    typedef logic signed [PROD_W+1:0] t_wide;

    localparam logic [CIDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 28'd838861;
    localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 28'd838861;
    localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 28'd167772;

    localparam t_wide SAT_MAX = t_wide'(64'sd2147483647);
    localparam t_wide SAT_MIN = t_wide'(-64'sd2147483648);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_MWAIT = 9'b000000100,
        S_MWB   = 9'b000001000,
        S_DIV0  = 9'b000010000,
        S_DIV0W = 9'b000100000,
        S_DIV1  = 9'b001000000,
        S_DIV1W = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    typedef enum logic [3:0] {
        STEP_ANGLE_PRED = 4'd0,
        STEP_T          = 4'd1,
        STEP_P00_PRED   = 4'd2,
        STEP_P11_PRED   = 4'd3,
        STEP_ANGLE_COR  = 4'd4,
        STEP_BIAS_COR   = 4'd5,
        STEP_P00_COR    = 4'd6,
        STEP_P01_COR    = 4'd7,
        STEP_P10_COR    = 4'd8,
        STEP_P11_COR    = 4'd9
    } t_step;

    function automatic t_q sat32(input t_wide v);
        if (v > SAT_MAX) begin
            return 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            return 32'sh80000000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

    function automatic t_wide ext_q(input t_q v);
        return t_wide'(v);
    endfunction

    // Round to nearest with ties toward plus infinity, then floor shift.
    function automatic t_delta round_shift(input t_prod p, input logic q24);
        t_delta v;
        v = t_delta'(p) + (q24 ? t_delta'(64'sd8388608) : t_delta'(64'sd32768));
        return q24 ? (v >>> 24) : (v >>> 16);
    endfunction

endpackage

// ----- design/kalman_angle_bias_filter_unit.sv -----
// Top level of the angle and gyro-bias Kalman filter: state registers and
// the step sequencer. Depends on kabf_pkg, kabf_mul and kabf_div.
//
//  channel | signals                                             | dir
//  input   | i_valid/o_ready, command, measured angle/rate, step | in
//  result  | o_valid/i_ready, o_filtered_angle                   | out
//  config  | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data    | in
//
// A filter word runs from acceptance through ten multiplies on the shared multiplier,
// each in S_MUL, S_MWAIT and S_MWB, two divisions for the gains (start, 56 quotient
// bits, done) and loading the result. A force word sets the angle on acceptance and
// goes straight to loading the result. Reset restores the noise defaults and zeroes
// the estimates and covariance. The next word is taken once the result sits in the
// output register; a stalled output holds the sequencer in its last state.
module kalman_angle_bias_filter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic signed [24:0]            i_measured_angle,
    input  logic signed [31:0]            i_measured_rate,
    input  logic [19:0]                   i_time_step,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_filtered_angle,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kabf_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [kabf_pkg::CFG_W-1:0]    i_cfg_data
);
    import kabf_pkg::*;

    t_state r_state;
    t_step  r_step;

    logic [CFG_W-1:0] r_angle_noise;
    logic [CFG_W-1:0] r_bias_noise;
    logic [CFG_W-1:0] r_meas_noise;

    t_q r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    t_q r_t, r_k0, r_k1, r_y, r_p00t, r_p01t, r_rate_in, r_out;
    logic signed [MEAS_W-1:0] r_meas;
    logic [DT_W-1:0]          r_dt;
    logic                     r_out_valid;

    t_opnd  mul_a, mul_b, dt_op, den;
    t_prod  prod;
    t_delta delta;
    t_q     rate, inner, div_quot;
    logic   mul_load, div_start, div_done, in_acc;

    kabf_mul u_mul (
        .i_clk  (i_clk),
        .i_load (mul_load),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ((r_state == S_DIV0) ? r_p00 : r_p10),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_filtered_angle = r_out;
    assign in_acc      = i_valid && o_ready;
    assign mul_load    = (r_state == S_MUL);
    assign div_start   = (r_state == S_DIV0) || (r_state == S_DIV1);

    assign dt_op = t_opnd'({1'b0, r_dt});
    assign den   = t_opnd'(r_p00) + t_opnd'({1'b0, r_meas_noise});
    assign rate  = sat32(ext_q(r_rate_in) - ext_q(r_bias));
    assign inner = sat32(ext_q(r_t) - ext_q(r_p01) - ext_q(r_p10)
                         + t_wide'({1'b0, r_angle_noise}));
    assign delta = round_shift(prod, r_step >= STEP_ANGLE_COR);

    always_comb begin
        case (r_step)
            STEP_ANGLE_PRED: begin mul_a = dt_op; mul_b = t_opnd'(rate); end
            STEP_T:          begin mul_a = dt_op; mul_b = t_opnd'(r_p11); end
            STEP_P00_PRED:   begin mul_a = dt_op; mul_b = t_opnd'(inner); end
            STEP_P11_PRED:   begin mul_a = t_opnd'({1'b0, r_bias_noise}); mul_b = dt_op; end
            STEP_ANGLE_COR:  begin mul_a = t_opnd'(r_k0); mul_b = t_opnd'(r_y); end
            STEP_BIAS_COR:   begin mul_a = t_opnd'(r_k1); mul_b = t_opnd'(r_y); end
            STEP_P00_COR:    begin mul_a = t_opnd'(r_k0); mul_b = t_opnd'(r_p00t); end
            STEP_P01_COR:    begin mul_a = t_opnd'(r_k0); mul_b = t_opnd'(r_p01t); end
            STEP_P10_COR:    begin mul_a = t_opnd'(r_k1); mul_b = t_opnd'(r_p00t); end
            STEP_P11_COR:    begin mul_a = t_opnd'(r_k1); mul_b = t_opnd'(r_p01t); end
            default:         begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise <= ANGLE_NOISE_RST;
            r_bias_noise  <= BIAS_NOISE_RST;
            r_meas_noise  <= MEAS_NOISE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ANGLE_NOISE: r_angle_noise <= i_cfg_data;
                CFG_BIAS_NOISE:  r_bias_noise  <= i_cfg_data;
                CFG_MEAS_NOISE:  r_meas_noise  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_ANGLE_PRED;
            r_out_valid <= 1'b0;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= '0;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= '0;
        end else begin
            // In the done state the output register is handled below.
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_meas    <= i_measured_angle;
                        r_rate_in <= i_measured_rate;
                        r_dt      <= i_time_step;
                        r_step    <= STEP_ANGLE_PRED;
                        if (i_command) begin
                            r_angle <= t_q'(i_measured_angle);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL:   r_state <= S_MWAIT;
                S_MWAIT: r_state <= S_MWB;
                S_MWB: begin
                    r_state <= S_MUL;
                    r_step  <= t_step'(r_step + 4'd1);
                    case (r_step)
                        STEP_ANGLE_PRED: r_angle <= sat32(ext_q(r_angle) + t_wide'(delta));
                        STEP_T:          r_t     <= sat32(t_wide'(delta));
                        STEP_P00_PRED: begin
                            r_p00 <= sat32(ext_q(r_p00) + t_wide'(delta));
                            r_p01 <= sat32(ext_q(r_p01) - ext_q(r_t));
                            r_p10 <= sat32(ext_q(r_p10) - ext_q(r_t));
                        end
                        STEP_P11_PRED: begin
                            r_p11   <= sat32(ext_q(r_p11) + t_wide'(delta));
                            r_state <= S_DIV0;
                        end
                        STEP_ANGLE_COR:  r_angle <= sat32(ext_q(r_angle) + t_wide'(delta));
                        STEP_BIAS_COR:   r_bias  <= sat32(ext_q(r_bias) + t_wide'(delta));
                        STEP_P00_COR:    r_p00   <= sat32(ext_q(r_p00) - t_wide'(delta));
                        STEP_P01_COR:    r_p01   <= sat32(ext_q(r_p01) - t_wide'(delta));
                        STEP_P10_COR:    r_p10   <= sat32(ext_q(r_p10) - t_wide'(delta));
                        STEP_P11_COR: begin
                            r_p11   <= sat32(ext_q(r_p11) - t_wide'(delta));
                            r_state <= S_DONE;
                        end
                        default: ;
                    endcase
                end
                S_DIV0: begin
                    // The covariance terms used by the update are the
                    // predicted ones, so freeze them before any is corrected.
                    r_p00t  <= r_p00;
                    r_p01t  <= r_p01;
                    r_y     <= sat32(t_wide'(r_meas) - ext_q(r_angle));
                    r_state <= S_DIV0W;
                end
                S_DIV0W: begin
                    if (div_done) begin
                        r_k0    <= div_quot;
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: r_state <= S_DIV1W;
                S_DIV1W: begin
                    if (div_done) begin
                        r_k1    <= div_quot;
                        r_step  <= STEP_ANGLE_COR;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out       <= r_angle;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready) else $error("ready right after accepting a word");

    a_mul_pipeline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_MWAIT) ##1 (r_state == S_MWB))
        else $error("multiply steps out of order");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV0W || r_state == S_DIV1W))
        else $error("divider finished outside a wait state");

endmodule

// ----- design/kabf_mul.sv -----
// Shared signed multiplier with registered operands and product.
// Depends on kabf_pkg.
module kabf_mul (
    input  logic           i_clk,
    input  logic           i_load,
    input  kabf_pkg::t_opnd i_a,
    input  kabf_pkg::t_opnd i_b,
    output kabf_pkg::t_prod o_prod
);
    import kabf_pkg::*;

    t_opnd r_a;
    t_opnd r_b;
    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_prod <= r_a * r_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- design/kabf_div.sv -----
// Restoring divider, one quotient bit a cycle: (num * 2^24) / den, truncated
// toward zero and saturated to 32 bits. Depends on kabf_pkg.
module kabf_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  kabf_pkg::t_q     i_num,
    input  kabf_pkg::t_opnd  i_den,
    output logic             o_done,
    output kabf_pkg::t_q     o_quot
);
    import kabf_pkg::*;

    localparam int NUM_W = DATA_W + 24;
    localparam int REM_W = OPND_W + 1;
    localparam logic [5:0] CNT_INIT = 6'(NUM_W);

    logic [NUM_W-1:0]  r_num;
    logic [OPND_W-1:0] r_den;
    logic [REM_W-1:0]  r_rem;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic              r_zero;

    logic [DATA_W-1:0] num_abs;
    logic [OPND_W-1:0] den_abs;
    logic [REM_W-1:0]  rem_sh;
    logic              q_bit;

    assign num_abs = i_num[DATA_W-1] ? DATA_W'(-i_num) : DATA_W'(i_num);
    assign den_abs = i_den[OPND_W-1] ? OPND_W'(-i_den) : OPND_W'(i_den);
    assign rem_sh  = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_INIT;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num  <= {num_abs, 24'd0};
            r_den  <= den_abs;
            r_rem  <= '0;
            r_neg  <= i_num[DATA_W-1] ^ i_den[OPND_W-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_num <= {r_num[NUM_W-2:0], q_bit};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (!r_neg) begin
            o_quot = (r_num > NUM_W'(64'd2147483647)) ? 32'sh7fffffff
                                                       : t_q'(r_num[DATA_W-1:0]);
        end else begin
            o_quot = (r_num > NUM_W'(64'd2147483648)) ? 32'sh80000000
                                                       : t_q'(-r_num[DATA_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule
